// ===== hw/rtl/bfmp_pkg.sv =====
// Shared types and constants for the brace-framed message parser.
`timescale 1ns / 1ps
`default_nettype none

package bfmp_pkg;

  // Parser phase; codes 6 and 7 are unused and fall back to hunt.
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_TYPE    = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CLOSE   = 3'd4,
    PH_SUBTYPE = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    EV_PAYLOAD  = 3'd0,
    EV_COMPLETE = 3'd1,
    EV_BAD_TYPE = 3'd2,
    EV_BAD_SUB  = 3'd3,
    EV_NO_CLOSE = 3'd4
  } event_t;

  // Frame type codes
  localparam logic [2:0] FT_COMMAND  = 3'd0;
  localparam logic [2:0] FT_MESSAGE  = 3'd1;
  localparam logic [2:0] FT_ERROR    = 3'd2;
  localparam logic [2:0] FT_BUTTON   = 3'd3;
  localparam logic [2:0] FT_ROTATION = 3'd4;
  localparam logic [2:0] FT_SLIDER   = 3'd5;

  // Framing characters (ASCII)
  localparam logic [7:0] CH_OPEN  = 8'h7B;  // '{'
  localparam logic [7:0] CH_CLOSE = 8'h7D;  // '}'
  localparam logic [7:0] CH_CMD   = 8'h43;  // 'C'
  localparam logic [7:0] CH_DATA  = 8'h44;  // 'D'
  localparam logic [7:0] CH_MSG   = 8'h4D;  // 'M'
  localparam logic [7:0] CH_ERR   = 8'h58;  // 'X'
  localparam logic [7:0] CH_BTN   = 8'h42;  // 'B'
  localparam logic [7:0] CH_ROT   = 8'h52;  // 'R'
  localparam logic [7:0] CH_SLD   = 8'h53;  // 'S'

  // Data frames carry a fixed payload with no length byte
  localparam logic [7:0] DATA_PAYLOAD_LEN = 8'd2;

  typedef struct packed {
    event_t     kind;
    logic [2:0] ftype;
    logic [7:0] pbyte;
    logic [7:0] pidx;
    logic [7:0] plen;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bfmp_step.sv =====
// Frame state machine: parser state registers and the per-byte step logic.
`timescale 1ns / 1ps
`default_nettype none

module bfmp_step (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        byte_i,
  input  wire logic              fire,
  output logic                   has_result,
  output bfmp_pkg::result_t      result
);

  bfmp_pkg::phase_t phase_r, phase_nxt;
  logic [2:0] type_r, type_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;

  logic [8:0] cnt_inc;
  logic       last_byte;

  assign cnt_inc   = {1'b0, cnt_r} + 9'd1;
  assign last_byte = (cnt_inc >= {1'b0, len_r});

  // next state
  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    case (phase_r)
      bfmp_pkg::PH_HUNT: begin
        if (byte_i == bfmp_pkg::CH_OPEN) begin
          type_nxt  = bfmp_pkg::FT_COMMAND;
          len_nxt   = 8'd0;
          cnt_nxt   = 8'd0;
          phase_nxt = bfmp_pkg::PH_TYPE;
        end
      end
      bfmp_pkg::PH_TYPE: begin
        case (byte_i)
          bfmp_pkg::CH_CMD: begin
            type_nxt  = bfmp_pkg::FT_COMMAND;
            phase_nxt = bfmp_pkg::PH_LENGTH;
          end
          bfmp_pkg::CH_MSG: begin
            type_nxt  = bfmp_pkg::FT_MESSAGE;
            phase_nxt = bfmp_pkg::PH_LENGTH;
          end
          bfmp_pkg::CH_ERR: begin
            type_nxt  = bfmp_pkg::FT_ERROR;
            phase_nxt = bfmp_pkg::PH_LENGTH;
          end
          bfmp_pkg::CH_DATA: begin
            phase_nxt = bfmp_pkg::PH_SUBTYPE;
          end
          default: begin
            phase_nxt = bfmp_pkg::PH_HUNT;
          end
        endcase
      end
      bfmp_pkg::PH_LENGTH: begin
        len_nxt   = byte_i;
        cnt_nxt   = 8'd0;
        phase_nxt = (byte_i == 8'd0) ? bfmp_pkg::PH_CLOSE : bfmp_pkg::PH_PAYLOAD;
      end
      bfmp_pkg::PH_PAYLOAD: begin
        cnt_nxt = cnt_inc[7:0];
        if (last_byte) begin
          phase_nxt = bfmp_pkg::PH_CLOSE;
        end
      end
      bfmp_pkg::PH_CLOSE: begin
        phase_nxt = bfmp_pkg::PH_HUNT;
      end
      bfmp_pkg::PH_SUBTYPE: begin
        if (byte_i inside {bfmp_pkg::CH_BTN, bfmp_pkg::CH_ROT, bfmp_pkg::CH_SLD}) begin
          case (byte_i)
            bfmp_pkg::CH_BTN: type_nxt = bfmp_pkg::FT_BUTTON;
            bfmp_pkg::CH_ROT: type_nxt = bfmp_pkg::FT_ROTATION;
            default:          type_nxt = bfmp_pkg::FT_SLIDER;
          endcase
          len_nxt   = bfmp_pkg::DATA_PAYLOAD_LEN;
          cnt_nxt   = 8'd0;
          phase_nxt = bfmp_pkg::PH_PAYLOAD;
        end else begin
          phase_nxt = bfmp_pkg::PH_HUNT;
        end
      end
      default: begin
        phase_nxt = bfmp_pkg::PH_HUNT;
      end
    endcase
  end

  // result for this byte
  always_comb begin
    has_result   = 1'b0;
    result.kind  = bfmp_pkg::EV_PAYLOAD;
    result.ftype = bfmp_pkg::FT_COMMAND;
    result.pbyte = 8'd0;
    result.pidx  = 8'd0;
    result.plen  = 8'd0;
    result.last  = 1'b0;
    case (phase_r)
      bfmp_pkg::PH_TYPE: begin
        if (!(byte_i inside {bfmp_pkg::CH_CMD, bfmp_pkg::CH_MSG, bfmp_pkg::CH_ERR,
                             bfmp_pkg::CH_DATA})) begin
          has_result  = 1'b1;
          result.kind = bfmp_pkg::EV_BAD_TYPE;
        end
      end
      bfmp_pkg::PH_PAYLOAD: begin
        has_result   = 1'b1;
        result.kind  = bfmp_pkg::EV_PAYLOAD;
        result.ftype = type_r;
        result.pbyte = byte_i;
        result.pidx  = cnt_r;
        result.plen  = len_r;
        result.last  = last_byte;
      end
      bfmp_pkg::PH_CLOSE: begin
        has_result   = 1'b1;
        result.kind  = (byte_i == bfmp_pkg::CH_CLOSE) ? bfmp_pkg::EV_COMPLETE
                                                      : bfmp_pkg::EV_NO_CLOSE;
        result.ftype = type_r;
        result.plen  = len_r;
      end
      bfmp_pkg::PH_SUBTYPE: begin
        if (!(byte_i inside {bfmp_pkg::CH_BTN, bfmp_pkg::CH_ROT, bfmp_pkg::CH_SLD})) begin
          has_result  = 1'b1;
          result.kind = bfmp_pkg::EV_BAD_SUB;
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bfmp_pkg::PH_HUNT;
      type_r  <= 3'd0;
      len_r   <= 8'd0;
      cnt_r   <= 8'd0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bfmp_out_reg.sv =====
// Result register: holds one result beat until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none

module bfmp_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire bfmp_pkg::result_t res_i,
  output logic                   free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_event_kind,
  output logic [2:0]             out_frame_type,
  output logic [7:0]             out_payload_byte,
  output logic [7:0]             out_payload_index,
  output logic [7:0]             out_payload_length,
  output logic                   out_last_payload
);

  logic              valid_r;
  bfmp_pkg::result_t res_r;

  assign free = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res_i;
    end
  end

  assign out_valid          = valid_r;
  assign out_event_kind     = res_r.kind;
  assign out_frame_type     = res_r.ftype;
  assign out_payload_byte   = res_r.pbyte;
  assign out_payload_index  = res_r.pidx;
  assign out_payload_length = res_r.plen;
  assign out_last_payload   = res_r.last;

endmodule

`default_nettype wire

// ===== hw/rtl/brace_framed_message_parser.sv =====
// Top level of the brace-framed message parser: input stage, frame FSM, result register.
`timescale 1ns / 1ps
`default_nettype none

// Chan | Dir    | Handshake           | Beat fields
// -----+--------+---------------------+------------------------------------------------------
// in   | sink   | in_valid/in_ready   | in_rx_byte: one received byte
// out  | source | out_valid/out_ready | event_kind, frame_type, payload_byte/index/length, last
//
// One byte per cycle sustained unless a held result stalls the FSM. A byte is captured
// in the input register, then stepped through the frame FSM; its event (if any) is loaded
// into the result register at the same edge that updates the FSM state.
// Bytes that raise no event (hunt, length, valid type and subtype) never wait on out_ready.
// A held result stalls the FSM only when the next byte also raises an event.
// Synchronous active-low reset returns the parser to hunting for the open brace.

module brace_framed_message_parser (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_event_kind,
  output logic [2:0]      out_frame_type,
  output logic [7:0]      out_payload_byte,
  output logic [7:0]      out_payload_index,
  output logic [7:0]      out_payload_length,
  output logic            out_last_payload
);

  // input stage
  logic       stg_valid_r;
  logic [7:0] stg_byte_r;

  logic              has_result;
  bfmp_pkg::result_t step_res;
  logic              out_free;
  logic              fire;

  // the staged byte steps the FSM unless its event has nowhere to go
  assign fire     = stg_valid_r && (!has_result || out_free);
  assign in_ready = !stg_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ready) begin
      stg_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stg_byte_r <= in_rx_byte;
    end
  end

  bfmp_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_i     (stg_byte_r),
    .fire       (fire),
    .has_result (has_result),
    .result     (step_res)
  );

  bfmp_out_reg u_out (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (fire && has_result),
    .res_i              (step_res),
    .free               (out_free),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_kind     (out_event_kind),
    .out_frame_type     (out_frame_type),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_payload_length (out_payload_length),
    .out_last_payload   (out_last_payload)
  );

  // payload beats always sit inside the declared length
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind == bfmp_pkg::EV_PAYLOAD) |->
      (out_payload_index < out_payload_length))
    else $error("payload index beyond declared length");

  // last flag only on payload beats
  a_last_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_payload) |-> (out_event_kind == bfmp_pkg::EV_PAYLOAD))
    else $error("last flag on non-payload event");

  // type errors carry no frame info
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_event_kind == bfmp_pkg::EV_BAD_TYPE ||
                   out_event_kind == bfmp_pkg::EV_BAD_SUB)) |->
      (out_frame_type == bfmp_pkg::FT_COMMAND && out_payload_length == 8'd0))
    else $error("type error carries frame fields");

  // a staged byte that is not stepped is still there next cycle
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid_r && !fire) |=> (stg_valid_r && $stable(stg_byte_r)))
    else $error("staged byte lost");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Testbench for the brace-framed message parser: directed frames, then a random byte stream.
`timescale 1ns / 1ps

module testbench;

  localparam int RANDOM_ITEMS = 500;
  // Longest quiet stretch of a correct run is the longest drawn send gap plus the longest
  // drawn result stall plus the two-stage pipe; this is well past that.
  localparam int IDLE_LIMIT   = 1000;
  localparam int DRAIN_CYCLES = 8;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_event_kind;
  logic [2:0] out_frame_type;
  logic [7:0] out_payload_byte;
  logic [7:0] out_payload_index;
  logic [7:0] out_payload_length;
  logic       out_last_payload;

  brace_framed_message_parser DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_kind     (out_event_kind),
    .out_frame_type     (out_frame_type),
    .out_payload_byte   (out_payload_byte),
    .out_payload_index  (out_payload_index),
    .out_payload_length (out_payload_length),
    .out_last_payload   (out_last_payload)
  );

  always #10 clk = ~clk;

  // Parser state as the predictor sees it
  bfmp_pkg::phase_t parse_phase = bfmp_pkg::PH_HUNT;
  logic [2:0] frame_type = bfmp_pkg::FT_COMMAND;
  logic [7:0] frame_length = 8'd0;
  logic [7:0] payload_count = 8'd0;

  bfmp_pkg::result_t pending_events[$];

  int  mismatch_count = 0;
  int  bytes_pushed = 0;
  int  ignored_bytes = 0;
  int  sink_hold = 0;
  int  quiet_cycles = 0;
  // While set, neither side inserts gaps: back-to-back beats
  bit  calm = 1'b0;

  function automatic int pick_gap();
    if (calm) return 0;
    return $urandom_range(0, 19);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Steps the predicted parser by one accepted byte; queues the event it raises.
  task automatic predict_byte(input logic [7:0] b);
    bfmp_pkg::result_t ev;
    ev = '{kind: bfmp_pkg::EV_PAYLOAD, ftype: bfmp_pkg::FT_COMMAND, pbyte: 8'd0,
           pidx: 8'd0, plen: 8'd0, last: 1'b0};
    case (parse_phase)
      bfmp_pkg::PH_HUNT: begin
        if (b == bfmp_pkg::CH_OPEN) begin
          frame_type    = bfmp_pkg::FT_COMMAND;
          frame_length  = 8'd0;
          payload_count = 8'd0;
          parse_phase   = bfmp_pkg::PH_TYPE;
        end
      end
      bfmp_pkg::PH_TYPE: begin
        if (b == bfmp_pkg::CH_CMD) begin
          frame_type  = bfmp_pkg::FT_COMMAND;
          parse_phase = bfmp_pkg::PH_LENGTH;
        end else if (b == bfmp_pkg::CH_MSG) begin
          frame_type  = bfmp_pkg::FT_MESSAGE;
          parse_phase = bfmp_pkg::PH_LENGTH;
        end else if (b == bfmp_pkg::CH_ERR) begin
          frame_type  = bfmp_pkg::FT_ERROR;
          parse_phase = bfmp_pkg::PH_LENGTH;
        end else if (b == bfmp_pkg::CH_DATA) begin
          parse_phase = bfmp_pkg::PH_SUBTYPE;
        end else begin
          parse_phase = bfmp_pkg::PH_HUNT;
          ev.kind = bfmp_pkg::EV_BAD_TYPE;
          pending_events.push_back(ev);
        end
      end
      bfmp_pkg::PH_LENGTH: begin
        frame_length  = b;
        payload_count = 8'd0;
        parse_phase   = (b == 8'd0) ? bfmp_pkg::PH_CLOSE : bfmp_pkg::PH_PAYLOAD;
      end
      bfmp_pkg::PH_PAYLOAD: begin
        ev.kind  = bfmp_pkg::EV_PAYLOAD;
        ev.ftype = frame_type;
        ev.pbyte = b;
        ev.pidx  = payload_count;
        ev.plen  = frame_length;
        // 9-bit compare so index 255 cannot wrap
        ev.last  = ({1'b0, payload_count} + 9'd1 >= {1'b0, frame_length});
        pending_events.push_back(ev);
        payload_count = payload_count + 8'd1;
        if (ev.last) parse_phase = bfmp_pkg::PH_CLOSE;
      end
      bfmp_pkg::PH_CLOSE: begin
        parse_phase = bfmp_pkg::PH_HUNT;
        ev.kind  = (b == bfmp_pkg::CH_CLOSE) ? bfmp_pkg::EV_COMPLETE
                                             : bfmp_pkg::EV_NO_CLOSE;
        ev.ftype = frame_type;
        ev.plen  = frame_length;
        pending_events.push_back(ev);
      end
      bfmp_pkg::PH_SUBTYPE: begin
        if (b == bfmp_pkg::CH_BTN || b == bfmp_pkg::CH_ROT || b == bfmp_pkg::CH_SLD) begin
          frame_type    = (b == bfmp_pkg::CH_BTN) ? bfmp_pkg::FT_BUTTON :
                          (b == bfmp_pkg::CH_ROT) ? bfmp_pkg::FT_ROTATION :
                                                    bfmp_pkg::FT_SLIDER;
          frame_length  = bfmp_pkg::DATA_PAYLOAD_LEN;
          payload_count = 8'd0;
          parse_phase   = bfmp_pkg::PH_PAYLOAD;
        end else begin
          parse_phase = bfmp_pkg::PH_HUNT;
          ev.kind = bfmp_pkg::EV_BAD_SUB;
          pending_events.push_back(ev);
        end
      end
      default: parse_phase = bfmp_pkg::PH_HUNT;
    endcase
  endtask

  // Sends one byte beat. Valid stays high across back-to-back beats and is
  // dropped only when a gap is drawn.
  task automatic push_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_byte(b);
    bytes_pushed++;
  endtask

  // Compares one result beat against the oldest expected event.
  task automatic check_event();
    bfmp_pkg::result_t want;
    if (pending_events.size() == 0) begin
      report_mismatch($sformatf("result beat with nothing expected, kind %0d",
                                out_event_kind));
      return;
    end
    want = pending_events.pop_front();
    if (out_event_kind !== want.kind)
      report_mismatch($sformatf("event_kind got %0d expected %0d",
                                out_event_kind, want.kind));
    if (out_frame_type !== want.ftype)
      report_mismatch($sformatf("frame_type got %0d expected %0d",
                                out_frame_type, want.ftype));
    if (out_payload_byte !== want.pbyte)
      report_mismatch($sformatf("payload_byte got %0h expected %0h",
                                out_payload_byte, want.pbyte));
    if (out_payload_index !== want.pidx)
      report_mismatch($sformatf("payload_index got %0d expected %0d",
                                out_payload_index, want.pidx));
    if (out_payload_length !== want.plen)
      report_mismatch($sformatf("payload_length got %0d expected %0d",
                                out_payload_length, want.plen));
    if (out_last_payload !== want.last)
      report_mismatch($sformatf("last_payload got %0b expected %0b",
                                out_last_payload, want.last));
  endtask

  // Result side: check each beat, then hold ready low for a drawn stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_hold = 0;
    end else if (out_valid && out_ready) begin
      check_event();
      sink_hold = pick_gap();
      out_ready <= (sink_hold == 0);
    end else if (!out_ready) begin
      if (sink_hold <= 1) begin
        out_ready <= 1'b1;
        sink_hold = 0;
      end else begin
        sink_hold--;
      end
    end
  end

  // Watchdog: too long without any beat on either channel means a hang.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [7:0] pick_payload();
    // Framing characters inside a payload must pass through as plain data
    if ($urandom_range(0, 7) == 0)
      return ($urandom_range(0, 1) != 0) ? bfmp_pkg::CH_OPEN : bfmp_pkg::CH_CLOSE;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_type_char();
    case ($urandom_range(0, 3))
      0:       return bfmp_pkg::CH_CMD;
      1:       return bfmp_pkg::CH_MSG;
      2:       return bfmp_pkg::CH_ERR;
      default: return bfmp_pkg::CH_DATA;
    endcase
  endfunction

  function automatic logic [7:0] pick_sub_char();
    case ($urandom_range(0, 2))
      0:       return bfmp_pkg::CH_BTN;
      1:       return bfmp_pkg::CH_ROT;
      default: return bfmp_pkg::CH_SLD;
    endcase
  endfunction

  function automatic logic [7:0] pick_bad_type();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == bfmp_pkg::CH_CMD || b == bfmp_pkg::CH_MSG || b == bfmp_pkg::CH_ERR ||
           b == bfmp_pkg::CH_DATA)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  function automatic logic [7:0] pick_bad_sub();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == bfmp_pkg::CH_BTN || b == bfmp_pkg::CH_ROT || b == bfmp_pkg::CH_SLD)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Wrong closing byte; half the time an open brace, which must be eaten.
  function automatic logic [7:0] pick_bad_close();
    logic [7:0] b;
    if ($urandom_range(0, 1) != 0) return bfmp_pkg::CH_OPEN;
    b = 8'($urandom_range(0, 255));
    while (b == bfmp_pkg::CH_CLOSE) b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Whole frame with random payload; data frames ignore len.
  task automatic send_frame(input logic [7:0] type_ch, input logic [7:0] sub_ch,
                            input int len, input logic [7:0] close_ch);
    int n;
    push_byte(bfmp_pkg::CH_OPEN);
    push_byte(type_ch);
    if (type_ch == bfmp_pkg::CH_DATA) begin
      push_byte(sub_ch);
      n = int'(bfmp_pkg::DATA_PAYLOAD_LEN);
    end else begin
      push_byte(8'(len));
      n = len;
    end
    for (int i = 0; i < n; i++) push_byte(pick_payload());
    push_byte(close_ch);
  endtask

  task automatic test_hunt_noise();
    // Anything but an open brace is dropped while hunting
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(bfmp_pkg::CH_CLOSE);
  endtask

  task automatic test_length_frames();
    // command with one byte, error message with zero length
    push_byte(bfmp_pkg::CH_OPEN); push_byte(bfmp_pkg::CH_CMD); push_byte(8'd1);
    push_byte(8'hFF); push_byte(bfmp_pkg::CH_CLOSE);
    push_byte(bfmp_pkg::CH_OPEN); push_byte(bfmp_pkg::CH_ERR); push_byte(8'd0);
    push_byte(bfmp_pkg::CH_CLOSE);
    // message whose close is an open brace: the brace is consumed, so the
    // following 'D' falls on the hunt and is dropped
    push_byte(bfmp_pkg::CH_OPEN); push_byte(bfmp_pkg::CH_MSG); push_byte(8'd1);
    push_byte(8'h00);
    push_byte(bfmp_pkg::CH_OPEN);
    push_byte(bfmp_pkg::CH_DATA);
  endtask

  task automatic test_data_frames();
    push_byte(bfmp_pkg::CH_OPEN); push_byte(bfmp_pkg::CH_DATA); push_byte(bfmp_pkg::CH_BTN);
    push_byte(bfmp_pkg::CH_OPEN); push_byte(bfmp_pkg::CH_CLOSE);
    push_byte(bfmp_pkg::CH_CLOSE);
    push_byte(bfmp_pkg::CH_OPEN); push_byte(bfmp_pkg::CH_DATA); push_byte(bfmp_pkg::CH_ROT);
    push_byte(8'h00); push_byte(8'hFF); push_byte(bfmp_pkg::CH_CLOSE);
    push_byte(bfmp_pkg::CH_OPEN); push_byte(bfmp_pkg::CH_DATA); push_byte(bfmp_pkg::CH_SLD);
    push_byte(8'h80); push_byte(8'h7F); push_byte(8'h41);
  endtask

  task automatic test_bad_headers();
    push_byte(bfmp_pkg::CH_OPEN); push_byte(bfmp_pkg::CH_DATA); push_byte(8'h00);
    push_byte(bfmp_pkg::CH_OPEN); push_byte(8'hFF);
  endtask

  // Mostly well-formed frames with random content; some broken headers,
  // missing closes and hunt noise. One maximum-length frame.
  task automatic test_random_stream();
    int base_count;
    int long_at;
    int frame_no;
    int pick;
    int len;
    base_count = bytes_pushed - ignored_bytes;
    long_at    = $urandom_range(3, 25);
    frame_no   = 0;
    while (bytes_pushed - ignored_bytes - base_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) calm = ~calm;
      pick = $urandom_range(0, 99);
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
      if (frame_no == long_at) begin
        send_frame(($urandom_range(0, 1) != 0) ? bfmp_pkg::CH_MSG : bfmp_pkg::CH_CMD,
                   bfmp_pkg::CH_BTN, 255, bfmp_pkg::CH_CLOSE);
      end else if (pick < 8) begin
        for (int i = $urandom_range(1, 3); i > 0; i--) begin
          pick = $urandom_range(0, 255);
          if (8'(pick) != bfmp_pkg::CH_OPEN) begin
            push_byte(8'(pick));
            ignored_bytes++;
          end
        end
      end else if (pick < 14) begin
        push_byte(bfmp_pkg::CH_OPEN);
        push_byte(pick_bad_type());
      end else if (pick < 20) begin
        push_byte(bfmp_pkg::CH_OPEN);
        push_byte(bfmp_pkg::CH_DATA);
        push_byte(pick_bad_sub());
      end else if (pick < 30) begin
        send_frame(pick_type_char(), pick_sub_char(), len, pick_bad_close());
      end else begin
        send_frame(pick_type_char(), pick_sub_char(), len, bfmp_pkg::CH_CLOSE);
      end
      frame_no++;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_hunt_noise();
    test_length_frames();
    test_data_frames();
    test_bad_headers();
    test_random_stream();

    in_valid <= 1'b0;
    // Bounded by the watchdog if a result never comes
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_events.size() != 0)
      report_mismatch($sformatf("%0d expected events never arrived",
                                pending_events.size()));

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
